>>> rtl/core/psrt_pkg.sv
// Package for the streaming point transform: fixed-point widths, register codes,
// configuration and per-stage payload types.
// No dependencies; compiled first.
package psrt_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned ROT_W      = 16;
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned ROT_FRAC   = 14;
  localparam int unsigned SCALED_W   = COORD_W + SCALE_W - SCALE_FRAC;
  localparam int unsigned PROD_W     = ROT_W + SCALED_W - ROT_FRAC;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3 * ROT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_ROT_ROW0 = 3'd1,
    REG_ROT_ROW1 = 3'd2,
    REG_ROT_ROW2 = 3'd3,
    REG_TRANS_X  = 3'd4,
    REG_TRANS_Y  = 3'd5,
    REG_TRANS_Z  = 3'd6
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [ROT_W-1:0]    rot_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SCALE_W-1:0]         scale_t;

  // Column 0 sits in the low bits of a row.
  typedef rot_t [2:0] rot_row_t;

  typedef struct packed {
    scale_t              scale;
    rot_row_t [2:0]      rot;
    coord_t   [2:0]      trans;
  } cfg_t;

  typedef struct packed {
    coord_t [2:0] c;
    logic         last;
  } point_t;

  typedef struct packed {
    scaled_t [2:0] s;
    logic          last;
  } scaled_pt_t;

  typedef struct packed {
    prod_t [2:0][2:0] p;
    logic             last;
  } rotated_pt_t;

  typedef struct packed {
    coord_t [2:0] c;
    logic         last;
    logic         saturated;
  } result_t;

  localparam coord_t SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

>>> rtl/core/psrt_if.sv
// Channel interfaces of the point transform: input points, results and
// register writes. Depends on psrt_pkg.
interface psrt_in_if;
  import psrt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_in;
  coord_t y_in;
  coord_t z_in;
  logic   last_in;
  modport source (output valid, output x_in, output y_in, output z_in, output last_in,
                  input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, input last_in,
                  output ready);
endinterface

interface psrt_out_if;
  import psrt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t y_out;
  coord_t z_out;
  logic   last_out;
  logic   saturated;
  modport source (output valid, output x_out, output y_out, output z_out,
                  output last_out, output saturated, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out,
                  input last_out, input saturated, output ready);
endinterface

interface psrt_cfg_if;
  import psrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/psrt_scale.sv
// First pipeline stage: multiplies each coordinate by the uniform scale.
// Depends on psrt_pkg.
module psrt_scale (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  psrt_pkg::point_t        point_i,
  input  psrt_pkg::scale_t        scale_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output psrt_pkg::scaled_pt_t    data_o
);
  import psrt_pkg::*;

  localparam int unsigned MUL_W = COORD_W + SCALE_W + 1;

  logic       valid_q;
  scaled_pt_t data_d, data_q;

  always_comb begin
    logic signed [MUL_W-1:0] prod;
    data_d = '0;
    for (int j = 0; j < 3; j++) begin
      prod = point_i.c[j] * $signed({1'b0, scale_i});
      // The arithmetic shift floors; the result always fits the scaled width.
      data_d.s[j] = prod[SCALED_W+SCALE_FRAC-1:SCALE_FRAC];
    end
    data_d.last = point_i.last;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/psrt_rotate.sv
// Second pipeline stage: the nine rotation products of the scaled point.
// Depends on psrt_pkg.
module psrt_rotate (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  psrt_pkg::scaled_pt_t    data_i,
  input  psrt_pkg::rot_row_t [2:0] rot_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output psrt_pkg::rotated_pt_t   data_o
);
  import psrt_pkg::*;

  localparam int unsigned MUL_W = ROT_W + SCALED_W;

  logic        valid_q;
  rotated_pt_t data_d, data_q;

  always_comb begin
    logic signed [MUL_W-1:0] prod;
    data_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod = $signed(rot_i[i][j]) * $signed(data_i.s[j]);
        data_d.p[i][j] = prod[PROD_W+ROT_FRAC-1:ROT_FRAC];
      end
    end
    data_d.last = data_i.last;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/psrt_sum_sat.sv
// Last two pipeline stages: row sums plus translation, then saturation into
// the output register. Depends on psrt_pkg.
module psrt_sum_sat (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  psrt_pkg::rotated_pt_t   data_i,
  input  psrt_pkg::coord_t [2:0]  trans_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output psrt_pkg::result_t       result_o
);
  import psrt_pkg::*;

  logic       sum_valid_q;
  sum_t [2:0] sum_d, sum_q;
  logic       sum_last_q;
  logic       sum_ready;

  logic       out_valid_q;
  logic       out_ready;
  result_t    res_d, res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = {{(SUM_W-PROD_W){data_i.p[i][0][PROD_W-1]}}, data_i.p[i][0]}
               + {{(SUM_W-PROD_W){data_i.p[i][1][PROD_W-1]}}, data_i.p[i][1]}
               + {{(SUM_W-PROD_W){data_i.p[i][2][PROD_W-1]}}, data_i.p[i][2]}
               + {{(SUM_W-COORD_W){trans_i[i][COORD_W-1]}}, trans_i[i]};
    end
  end

  // A sum fits when all bits from the sign down to bit 31 agree.
  always_comb begin
    logic [SUM_W-COORD_W:0] upper;
    res_d = '0;
    for (int i = 0; i < 3; i++) begin
      upper = sum_q[i][SUM_W-1:COORD_W-1];
      if ((&upper) || !(|upper)) begin
        res_d.c[i] = sum_q[i][COORD_W-1:0];
      end else begin
        res_d.c[i]      = sum_q[i][SUM_W-1] ? SAT_MIN : SAT_MAX;
        res_d.saturated = 1'b1;
      end
    end
    res_d.last = sum_last_q;
  end

  assign out_ready = !out_valid_q || ready_i;
  assign sum_ready = !sum_valid_q || out_ready;
  assign ready_o   = sum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && sum_ready) begin
      sum_q      <= sum_d;
      sum_last_q <= data_i.last;
    end
    if (sum_valid_q && out_ready) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

endmodule

>>> rtl/core/point_scale_rotate_translate.sv
// The result of an input transfer shows valid after the register stages for scaling,
// rotation products, row sums and saturation.
// Throughput: one point per cycle; a stalled output holds the filled stages in place.
// Reset clears all valid bits at once and loads unit scale, the identity rotation and
// zero translation; register writes are taken in every cycle.
module point_scale_rotate_translate (
  input  logic      clk_i,
  input  logic      rst_ni,
  psrt_in_if.sink   in_i,
  psrt_out_if.source out_o,
  psrt_cfg_if.sink  cfg_i
);
  import psrt_pkg::*;

  localparam rot_t ROT_ONE = rot_t'(1 << ROT_FRAC);

  cfg_t        cfg_q;
  point_t      point;
  logic        s1_valid, s1_ready;
  scaled_pt_t  s1_data;
  logic        s2_valid, s2_ready;
  rotated_pt_t s2_data;
  result_t     result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale  <= scale_t'(1 << SCALE_FRAC);
      cfg_q.rot[0] <= {rot_t'(0), rot_t'(0), ROT_ONE};
      cfg_q.rot[1] <= {rot_t'(0), ROT_ONE, rot_t'(0)};
      cfg_q.rot[2] <= {ROT_ONE, rot_t'(0), rot_t'(0)};
      cfg_q.trans  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SCALE:    cfg_q.scale    <= cfg_i.data[SCALE_W-1:0];
        REG_ROT_ROW0: cfg_q.rot[0]   <= cfg_i.data;
        REG_ROT_ROW1: cfg_q.rot[1]   <= cfg_i.data;
        REG_ROT_ROW2: cfg_q.rot[2]   <= cfg_i.data;
        REG_TRANS_X:  cfg_q.trans[0] <= cfg_i.data[COORD_W-1:0];
        REG_TRANS_Y:  cfg_q.trans[1] <= cfg_i.data[COORD_W-1:0];
        REG_TRANS_Z:  cfg_q.trans[2] <= cfg_i.data[COORD_W-1:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  assign point = {in_i.z_in, in_i.y_in, in_i.x_in, in_i.last_in};

  psrt_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .point_i (point),
    .scale_i (cfg_q.scale),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  psrt_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .rot_i   (cfg_q.rot),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  psrt_sum_sat u_sum_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .ready_o  (s2_ready),
    .data_i   (s2_data),
    .trans_i  (cfg_q.trans),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (result)
  );

  assign out_o.x_out     = result.c[0];
  assign out_o.y_out     = result.c[1];
  assign out_o.z_out     = result.c[2];
  assign out_o.last_out  = result.last;
  assign out_o.saturated = result.saturated;

endmodule

>>> rtl/core/psrt_checker.sv
// Port-level checks for the point transform, bound to the top level.
// Depends on psrt_pkg and point_scale_rotate_translate.
module psrt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input psrt_pkg::coord_t x_out_i,
  input psrt_pkg::coord_t y_out_i,
  input psrt_pkg::coord_t z_out_i,
  input logic             last_out_i,
  input logic             saturated_i
);
  import psrt_pkg::*;

  localparam int unsigned DEPTH = 4;

  logic       in_xfer, out_xfer;
  logic [2:0] count_d, count_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (in_xfer && !out_xfer) begin
      count_d = count_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Never more points inside than there are stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 3'(DEPTH))
    else $error("more points in flight than pipeline stages");

  // A result only appears for a point that was taken in.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> count_q != 3'd0)
    else $error("result without an outstanding point");

  // A flagged result carries at least one clamped coordinate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && saturated_i) |->
      (x_out_i == SAT_MAX || x_out_i == SAT_MIN || y_out_i == SAT_MAX ||
       y_out_i == SAT_MIN || z_out_i == SAT_MAX || z_out_i == SAT_MIN))
    else $error("saturation flag without a clamped coordinate");

  // With the output side taking transfers, every stage can advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_i)
    else $error("input stalled while output is ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(x_out_i) && $stable(y_out_i) && $stable(z_out_i) &&
       $stable(last_out_i) && $stable(saturated_i)))
    else $error("stalled result changed");

endmodule

bind point_scale_rotate_translate psrt_checker u_psrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .x_out_i     (out_o.x_out),
  .y_out_i     (out_o.y_out),
  .z_out_i     (out_o.z_out),
  .last_out_i  (out_o.last_out),
  .saturated_i (out_o.saturated)
);
